// ===== rtl/core/u8d_pkg.sv =====
// Shared types, constants and lead byte decode for the UTF-8 stream decoder.
`default_nettype none
package u8d_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  localparam int CP_W  = 21;
  localparam int CNT_W = 2;

  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD_MIN    = 8'hC2;
  localparam logic [7:0] LEAD_MAX    = 8'hF4;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD3_FIRST = 8'hE0;
  localparam logic [7:0] LEAD3_SURR  = 8'hED;
  localparam logic [7:0] LEAD4_FIRST = 8'hF0;
  localparam logic [7:0] LEAD4_LAST  = 8'hF4;
  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] CONT_HI     = 8'hBF;
  localparam logic [7:0] E0_LO       = 8'hA0;
  localparam logic [7:0] ED_HI       = 8'h9F;
  localparam logic [7:0] F0_LO       = 8'h90;
  localparam logic [7:0] F4_HI       = 8'h8F;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CP_W-1:0] cp;
    status_t         status;
  } res_t;

  // one accepted item that yields one or two results
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } job_t;

  // outcome of handling a byte as a lead byte from a clear sequence
  typedef struct packed {
    logic             emit;
    res_t             res;
    logic [CNT_W-1:0] needed;
    logic [CP_W-1:0]  partial;
    logic [7:0]       lo;
    logic [7:0]       hi;
  } lead_t;

  function automatic lead_t lead_eval(input logic [7:0] b);
    lead_t l;
    l.emit       = 1'b0;
    l.res.cp     = '0;
    l.res.status = ST_OK;
    l.needed     = '0;
    l.partial    = '0;
    l.lo         = CONT_LO;
    l.hi         = CONT_HI;
    if (b <= ASCII_MAX) begin
      l.emit   = 1'b1;
      l.res.cp = CP_W'(b);
    end else if (b < LEAD_MIN || b > LEAD_MAX) begin
      l.emit       = 1'b1;
      l.res.status = ST_BAD_LEAD;
    end else if (b <= LEAD2_MAX) begin
      l.needed  = 2'd1;
      l.partial = CP_W'(b[4:0]);
    end else if (b <= LEAD3_MAX) begin
      if (b == LEAD3_FIRST) l.lo = E0_LO;
      else if (b == LEAD3_SURR) l.hi = ED_HI;
      l.needed  = 2'd2;
      l.partial = CP_W'(b[3:0]);
    end else begin
      if (b == LEAD4_FIRST) l.lo = F0_LO;
      else if (b == LEAD4_LAST) l.hi = F4_HI;
      l.needed  = 2'd3;
      l.partial = CP_W'(b[2:0]);
    end
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/u8d_if.sv =====
// Valid/ready channel interfaces for byte input and decoded results.
`default_nettype none
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;
  modport source (output valid, data_byte, end_marker, input ready);
  modport sink   (input valid, data_byte, end_marker, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;
  logic        run_last;
  modport source (output valid, code_point, status, run_last, input ready);
  modport sink   (input valid, code_point, status, run_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder.
// Usage:
//  - in_ch carries one item per handshake: a raw byte, or an end marker.
//  - out_ch carries decoded results: code point, status, and run_last,
//    which flags the final result caused by one input item.
//  - An item makes zero, one or two results; two only when a bad
//    continuation byte is then taken again as a lead byte.
//  - Path: a taken item's job enters the queue at the accepting edge, and
//    the output register loads it from the queue head once that register
//    is empty or out_ch.ready is high.
//  - Throughput: one item per cycle while the queue is not full; one result
//    per cycle while out_ch.ready is high; two results of one item go in turn.
//  - The front stalls only when the four-entry job queue is full, so an
//    out_ch stall is absorbed by up to four jobs plus the output register.
//  - Reset (rst_n low, synchronous) clears the open sequence, empties the
//    queue and drops out_ch.valid; no results are lost beyond that point.
`default_nettype none
module utf8_stream_decoder (
  input  wire logic clk,
  input  wire logic rst_n,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch
);

  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  u8d_pkg::job_t push_job;
  u8d_pkg::job_t head;

  // byte classification and sequence tracking
  u8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // decouples decode from output stalls
  u8d_job_q u_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // one result per cycle into the output register while out_ch can take it
  u8d_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ===== rtl/core/u8d_front.sv =====
// Front end: accepts bytes, tracks the open sequence, builds result jobs.
`default_nettype none
module u8d_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  u8d_in_if.sink             in_ch,
  input  wire logic          q_full,
  output logic               push,
  output u8d_pkg::job_t      push_job
);

  logic [u8d_pkg::CP_W-1:0]  partial_r, partial_nxt;
  logic [u8d_pkg::CNT_W-1:0] needed_r, needed_nxt;
  logic [u8d_pkg::CNT_W-1:0] seen_r, seen_nxt;
  logic [7:0]                lo_r, lo_nxt;
  logic [7:0]                hi_r, hi_nxt;
  logic                      accept;
  logic [u8d_pkg::CNT_W-1:0] seen_inc;
  logic [u8d_pkg::CP_W-1:0]  partial_sh;
  u8d_pkg::lead_t            lead;
  logic [7:0]                b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;
  assign lead        = u8d_pkg::lead_eval(b);
  assign seen_inc    = seen_r + 2'd1;
  assign partial_sh  = {partial_r[u8d_pkg::CP_W-7:0], b[5:0]};

  always_comb begin
    partial_nxt = partial_r;
    needed_nxt  = needed_r;
    seen_nxt    = seen_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    push        = 1'b0;
    push_job    = '0;
    if (accept) begin
      if (in_ch.end_marker) begin
        if (needed_r != '0) begin
          partial_nxt = '0;
          needed_nxt  = '0;
          seen_nxt    = '0;
          lo_nxt      = u8d_pkg::CONT_LO;
          hi_nxt      = u8d_pkg::CONT_HI;
          push        = 1'b1;
          push_job.r0.status = u8d_pkg::ST_TRUNC;
        end
      end else if (needed_r == '0) begin
        partial_nxt = lead.partial;
        needed_nxt  = lead.needed;
        seen_nxt    = '0;
        lo_nxt      = lead.lo;
        hi_nxt      = lead.hi;
        push        = lead.emit;
        push_job.r0 = lead.res;
      end else if (b < lo_r || b > hi_r) begin
        // drop the sequence, report it, then retry the byte as a lead
        partial_nxt = lead.partial;
        needed_nxt  = lead.needed;
        seen_nxt    = '0;
        lo_nxt      = lead.lo;
        hi_nxt      = lead.hi;
        push        = 1'b1;
        push_job.r0.status = u8d_pkg::ST_BAD_CONT;
        push_job.two = lead.emit;
        push_job.r1  = lead.res;
      end else begin
        lo_nxt = u8d_pkg::CONT_LO;
        hi_nxt = u8d_pkg::CONT_HI;
        if (seen_inc == needed_r) begin
          partial_nxt    = '0;
          needed_nxt     = '0;
          seen_nxt       = '0;
          push           = 1'b1;
          push_job.r0.cp = partial_sh;
        end else begin
          partial_nxt = partial_sh;
          seen_nxt    = seen_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      needed_r  <= '0;
      seen_r    <= '0;
      lo_r      <= u8d_pkg::CONT_LO;
      hi_r      <= u8d_pkg::CONT_HI;
    end else begin
      partial_r <= partial_nxt;
      needed_r  <= needed_nxt;
      seen_r    <= seen_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/u8d_job_q.sv =====
// Small FIFO of result jobs between front and back.
`default_nettype none
module u8d_job_q (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire u8d_pkg::job_t push_job,
  input  wire logic          pop,
  output u8d_pkg::job_t      head,
  output logic               empty,
  output logic               full
);

  u8d_pkg::job_t            slots_r [u8d_pkg::QDEPTH];
  logic [u8d_pkg::QAW-1:0]  wptr_r, wptr_nxt;
  logic [u8d_pkg::QAW-1:0]  rptr_r, rptr_nxt;
  logic [u8d_pkg::QCW-1:0]  count_r, count_nxt;
  logic                     do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == u8d_pkg::QCW'(u8d_pkg::QDEPTH));
  assign head    = slots_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/u8d_back.sv =====
// Back end: unpacks jobs into single results behind an output register.
`default_nettype none
module u8d_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire u8d_pkg::job_t head,
  input  wire logic          empty,
  output logic               pop,
  u8d_out_if.source          out_ch
);

  logic                      valid_r, valid_nxt;
  logic                      sel_r, sel_nxt;
  u8d_pkg::res_t             res_r, res_nxt;
  logic                      last_r, last_nxt;
  logic                      load;
  logic                      job_last;

  assign load     = !empty && (!valid_r || out_ch.ready);
  assign job_last = !(head.two && !sel_r);
  assign pop      = load && job_last;

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = sel_r ? head.r1 : head.r0;
      last_nxt  = job_last;
      sel_nxt   = !job_last;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.code_point = res_r.cp;
  assign out_ch.status     = res_r.status;
  assign out_ch.run_last   = last_r;

endmodule
`default_nettype wire

// ===== rtl/core/u8d_checker.sv =====
// Port-level assertions for the UTF-8 stream decoder, bound to the top.
`default_nettype none
module u8d_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [20:0] out_code_point,
  input wire logic [1:0]  out_status,
  input wire logic        out_run_last
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point)
      && $stable(out_status) && $stable(out_run_last))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != u8d_pkg::ST_OK |-> out_code_point == '0)
    else $error("error result with nonzero code point");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == u8d_pkg::ST_TRUNC |-> out_run_last)
    else $error("truncation result not last of its item");

  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> out_status == u8d_pkg::ST_BAD_CONT)
    else $error("non-final result is not a bad continuation");

endmodule

bind utf8_stream_decoder u8d_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_code_point (out_ch.code_point),
  .out_status     (out_ch.status),
  .out_run_last   (out_ch.run_last)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
`timescale 1ns / 100ps
module tb;
  import u8d_pkg::*;

  localparam int RANDOM_BYTES = 600;
  localparam int GAP_PCT      = 23;
  // receiver hold-off: long enough to fill the job queue and the output register
  localparam int HOLD_CYCLES  = 120;
  // spare edges after the owed results, to catch stray results
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 100000;

  localparam logic [CP_W-1:0] BOUNDARY_SCALARS [10] = '{
    21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800,
    21'h00D7FF, 21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF
  };

  // one expected decoder result
  typedef struct {
    logic [CP_W-1:0] cp;
    status_t         status;
    logic            last;
  } scalar_t;

  // Tracks the decoder's sequence state and the results still owed on out_ch.
  class scalar_scoreboard;
    scalar_t          expected_scalars[$];
    int               errors;
    logic [CP_W-1:0]  partial_cp;
    logic [CNT_W-1:0] conts_needed;
    logic [CNT_W-1:0] conts_taken;
    logic [7:0]       cont_lo;
    logic [7:0]       cont_hi;

    function new();
      errors = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      partial_cp   = '0;
      conts_needed = '0;
      conts_taken  = '0;
      cont_lo      = CONT_LO;
      cont_hi      = CONT_HI;
    endfunction

    function void push_scalar(input logic [CP_W-1:0] cp, input status_t status);
      scalar_t s;
      s.cp     = cp;
      s.status = status;
      s.last   = 1'b0;
      expected_scalars.push_back(s);
    endfunction

    // byte seen with no sequence open
    function void open_lead(input logic [7:0] b);
      if (b <= ASCII_MAX) begin
        push_scalar(CP_W'(b), ST_OK);
      end else if (b < LEAD_MIN || b > LEAD_MAX) begin
        push_scalar('0, ST_BAD_LEAD);
      end else begin
        case (b[7:4])
          4'hC, 4'hD: begin
            conts_needed = 2'd1;
            partial_cp   = CP_W'(b[4:0]);
          end
          4'hE: begin
            conts_needed = 2'd2;
            partial_cp   = CP_W'(b[3:0]);
            if (b == LEAD3_FIRST) cont_lo = E0_LO;   // no overlong 3-byte forms
            if (b == LEAD3_SURR) cont_hi = ED_HI;    // no surrogates
          end
          default: begin
            conts_needed = 2'd3;
            partial_cp   = CP_W'(b[2:0]);
            if (b == LEAD4_FIRST) cont_lo = F0_LO;   // no overlong 4-byte forms
            if (b == LEAD4_LAST) cont_hi = F4_HI;    // nothing above 0x10FFFF
          end
        endcase
      end
    endfunction

    // accepted input item: advance the state and queue the results it owes
    function void decode_item(input logic [7:0] b, input logic eos);
      int n_queued;
      n_queued = expected_scalars.size();
      if (eos) begin
        if (conts_needed != 0) begin
          clear_sequence();
          push_scalar('0, ST_TRUNC);
        end
      end else if (conts_needed == 0) begin
        open_lead(b);
      end else if (b < cont_lo || b > cont_hi) begin
        // drop the sequence, then retry the same byte as a lead
        clear_sequence();
        push_scalar('0, ST_BAD_CONT);
        open_lead(b);
      end else begin
        cont_lo     = CONT_LO;
        cont_hi     = CONT_HI;
        conts_taken = conts_taken + 1'b1;
        partial_cp  = {partial_cp[CP_W-7:0], b[5:0]};
        if (conts_taken == conts_needed) begin
          push_scalar(partial_cp, ST_OK);
          clear_sequence();
        end
      end
      if (expected_scalars.size() > n_queued)
        expected_scalars[expected_scalars.size()-1].last = 1'b1;
    endfunction

    function void check_scalar(input logic [CP_W-1:0] cp, input logic [1:0] st,
                               input logic last);
      scalar_t want;
      if (expected_scalars.size() == 0) begin
        $error("unexpected result: code_point %h status %0d run_last %b", cp, st, last);
        errors++;
        return;
      end
      want = expected_scalars.pop_front();
      if (cp !== want.cp) begin
        $error("code_point: expected %h, got %h", want.cp, cp);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (last !== want.last) begin
        $error("run_last: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  u8d_in_if  in_ch ();
  u8d_out_if out_ch ();

  utf8_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scalar_scoreboard sb = new();

  int         tx_gap_pct = GAP_PCT;
  int         rx_gap_pct = GAP_PCT;
  logic       hold_req   = 1'b0;   // raised by the stimulus, taken by the receiver
  int         sent_bytes = 0;
  int         cycle_count;
  logic [7:0] seq_bytes[$];        // bytes of the sequence being built

  always #5 clk = ~clk;

  // Both monitors sample at the edge; a result passes through the job queue and
  // the output register after its item is taken, so the prediction is always queued before its check.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.decode_item(in_ch.data_byte, in_ch.end_marker);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_scalar(out_ch.code_point, out_ch.status, out_ch.run_last);
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_gap_pct);
      end
    end
  end

  // Offer one item and return at the edge where it is taken; valid stays up
  // so the next call can follow back to back.
  task automatic send_item(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.end_marker <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!eos) sent_bytes++;
  endtask

  // Spread picks over every encoded length, with the range limits mixed in.
  function automatic logic [CP_W-1:0] random_scalar();
    logic [CP_W-1:0] cp;
    case ($urandom_range(4))
      0: cp = CP_W'($urandom_range(32'h7F));
      1: cp = CP_W'($urandom_range(32'h7FF, 32'h80));
      2: begin
        cp = CP_W'($urandom_range(32'hFFFF, 32'h800));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h1000;  // step off surrogates
      end
      3: cp = CP_W'($urandom_range(32'h10FFFF, 32'h10000));
      default: cp = BOUNDARY_SCALARS[$urandom_range(9)];
    endcase
    return cp;
  endfunction

  task automatic build_sequence(input logic [CP_W-1:0] cp);
    seq_bytes.delete();
    if (cp < 21'h80) begin
      seq_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      seq_bytes.push_back({3'b110, cp[10:6]});
      seq_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      seq_bytes.push_back({4'b1110, cp[15:12]});
      seq_bytes.push_back({2'b10, cp[11:6]});
      seq_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      seq_bytes.push_back({5'b11110, cp[20:18]});
      seq_bytes.push_back({2'b10, cp[17:12]});
      seq_bytes.push_back({2'b10, cp[11:6]});
      seq_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  initial begin
    int   pick;
    int   cut;
    logic in_stretch;
    logic hold_done;
    hold_done = 1'b0;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.end_marker <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    send_item(8'h00, 1'b0);                 // smallest ASCII
    send_item(8'h7F, 1'b0);                 // largest ASCII
    send_item(8'hC2, 1'b0);                 // U+0080, smallest 2-byte
    send_item(8'h80, 1'b0);
    send_item(8'hE0, 1'b0);                 // U+0800, raised lower bound met exactly
    send_item(8'hA0, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hE0, 1'b0);                 // overlong 3-byte: bad cont, then bad lead
    send_item(8'h9F, 1'b0);
    send_item(8'hF4, 1'b0);                 // U+10FFFF, lowered upper bound met exactly
    send_item(8'h8F, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'hBF, 1'b0);
    send_item(8'hED, 1'b0);                 // surrogate: bad cont, then bad lead
    send_item(8'hA0, 1'b0);
    send_item(8'hFF, 1'b0);                 // bad leads at both ends of the range
    send_item(8'hC1, 1'b0);
    send_item(8'hC3, 1'b0);                 // bad cont retried as ASCII: two results
    send_item(8'h41, 1'b0);
    send_item(8'hF0, 1'b0);                 // bad cont that reopens as a 2-byte lead
    send_item(8'hC3, 1'b0);
    send_item(8'hA9, 1'b0);                 // completes U+00E9
    send_item(8'hE1, 1'b0);                 // end marker with a sequence open
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);                 // end marker with nothing open: no result

    // --- random ---
    // Mostly valid sequences with random content; the rest corrupted or cut
    // short, or plain noise. A middle stretch runs with no idling, and at its
    // start the receiver holds off while the sender keeps pushing.
    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      in_stretch = (sent_bytes >= 150 && sent_bytes < 400);
      tx_gap_pct = in_stretch ? 0 : GAP_PCT;
      rx_gap_pct = in_stretch ? 0 : GAP_PCT;
      if (in_stretch && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick >= 96) begin
        send_item(8'($urandom), 1'b1);
      end else if (pick >= 88) begin
        send_item(8'($urandom), 1'b0);
      end else begin
        build_sequence(random_scalar());
        if (pick >= 70 && pick < 80) begin
          // corrupt one byte, lead included
          seq_bytes[$urandom_range(seq_bytes.size() - 1)] = 8'($urandom);
        end else if (pick >= 80 && seq_bytes.size() > 1) begin
          // cut the sequence short
          cut = $urandom_range(seq_bytes.size() - 1, 1);
          while (seq_bytes.size() > cut) seq_bytes.delete(seq_bytes.size() - 1);
        end
        foreach (seq_bytes[i]) send_item(seq_bytes[i], 1'b0);
        if (pick >= 80 && $urandom_range(1) == 1) send_item(8'($urandom), 1'b1);
      end
    end
    in_ch.valid <= 1'b0;

    // drain: wait for every owed result, then a spare margin for stray results
    while (sb.expected_scalars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_scalars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
           sb.expected_scalars.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/u8d_pkg.sv
rtl/core/u8d_if.sv
rtl/core/u8d_front.sv
rtl/core/u8d_job_q.sv
rtl/core/u8d_back.sv
rtl/core/utf8_stream_decoder.sv
rtl/core/u8d_checker.sv
bench/tb.sv
